[hdl/drs_pkg.sv]
// Shared types and constants of the docking retry supervisor.
package drs_pkg;

  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned CountWidth   = 9;
  localparam int unsigned RetryWidth   = 4;
  localparam int unsigned LimitWidth   = 8;
  localparam int unsigned FwdThWidth   = 13;
  localparam int unsigned ThWidth      = 15;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 15;
  localparam int unsigned BackoutShift = 2;

  typedef enum logic [1:0] {
    OpStartDock   = 2'd0,
    OpStartUndock = 2'd1,
    OpTick        = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    StIdle         = 3'd0,
    StStarted      = 3'd1,
    StRunning      = 3'd2,
    StSucceeded    = 3'd3,
    StPreempted    = 3'd4,
    StRetriesOut   = 3'd5,
    StSensorAbort  = 3'd6,
    StUndockFailed = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    ClsRunning = 2'd0,
    ClsSuccess = 2'd1,
    ClsFailed  = 2'd2
  } class_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgErrorTickLimit  = 3'd0,
    CfgRetryLimit      = 3'd1,
    CfgForwardTh       = 3'd2,
    CfgLateralTh       = 3'd3,
    CfgHeadingTh       = 3'd4,
    CfgLinearLimit     = 3'd5,
    CfgAngularLimit    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic                         preempt_request;
    logic                         sensor_valid;
    logic signed [ValueWidth-1:0] proposed_linear;
    logic signed [ValueWidth-1:0] proposed_angular;
    logic signed [ValueWidth-1:0] fwd_error;
    logic signed [ValueWidth-1:0] lat_error;
    logic signed [ValueWidth-1:0] heading_error;
  } req_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic signed [ValueWidth-1:0] linear_command;
    logic signed [ValueWidth-1:0] angular_command;
    logic                         retry_target;
  } rsp_t;

  typedef struct packed {
    logic [LimitWidth-1:0] error_tick_limit;
    logic [RetryWidth-1:0] retry_limit;
    logic [FwdThWidth-1:0] forward_threshold;
    logic [ThWidth-1:0]    lateral_threshold;
    logic [ThWidth-1:0]    heading_threshold;
    logic [ThWidth-1:0]    linear_speed_limit;
    logic [ThWidth-1:0]    angular_speed_limit;
  } cfg_t;

  typedef struct packed {
    class_e                       cls;
    logic signed [ValueWidth-1:0] lin;
    logic signed [ValueWidth-1:0] ang;
  } eval_t;

endpackage

[hdl/drs_eval.sv]
// Velocity clamping and pose classification for one control tick.
module drs_eval (
  input  drs_pkg::req_t  req_i,
  input  drs_pkg::cfg_t  cfg_i,
  input  logic           backing_out_i,
  output drs_pkg::eval_t eval_o
);

  localparam int unsigned W = drs_pkg::ValueWidth + 1;

  logic signed [W-1:0] lin_x, ang_x, lin_lim, ang_lim, lin_nlim, ang_nlim;
  logic [W-1:0] fwd_mag, lat_mag, hdg_mag, thx, lat_th, hdg_th;

  assign lin_x    = {req_i.proposed_linear[drs_pkg::ValueWidth-1], req_i.proposed_linear};
  assign ang_x    = {req_i.proposed_angular[drs_pkg::ValueWidth-1], req_i.proposed_angular};
  assign lin_lim  = signed'({2'b00, cfg_i.linear_speed_limit});
  assign ang_lim  = signed'({2'b00, cfg_i.angular_speed_limit});
  assign lin_nlim = -lin_lim;
  assign ang_nlim = -ang_lim;

  // Magnitudes need one extra bit so that the most negative value stays exact.
  assign fwd_mag = req_i.fwd_error[drs_pkg::ValueWidth-1] ?
                   (W'(0) - W'(req_i.fwd_error)) : W'(unsigned'(req_i.fwd_error));
  assign lat_mag = req_i.lat_error[drs_pkg::ValueWidth-1] ?
                   (W'(0) - W'(req_i.lat_error)) : W'(unsigned'(req_i.lat_error));
  assign hdg_mag = req_i.heading_error[drs_pkg::ValueWidth-1] ?
                   (W'(0) - W'(req_i.heading_error)) : W'(unsigned'(req_i.heading_error));

  // The forward window widens fourfold while the target is the back-out offset.
  assign thx    = backing_out_i ?
                  W'({cfg_i.forward_threshold, {drs_pkg::BackoutShift{1'b0}}}) :
                  W'(cfg_i.forward_threshold);
  assign lat_th = W'(cfg_i.lateral_threshold);
  assign hdg_th = W'(cfg_i.heading_threshold);

  always_comb begin
    if (lin_x > lin_lim) begin
      eval_o.lin = lin_lim[drs_pkg::ValueWidth-1:0];
    end else if (lin_x < lin_nlim) begin
      eval_o.lin = lin_nlim[drs_pkg::ValueWidth-1:0];
    end else begin
      eval_o.lin = req_i.proposed_linear;
    end

    if (ang_x > ang_lim) begin
      eval_o.ang = ang_lim[drs_pkg::ValueWidth-1:0];
    end else if (ang_x < ang_nlim) begin
      eval_o.ang = ang_nlim[drs_pkg::ValueWidth-1:0];
    end else begin
      eval_o.ang = req_i.proposed_angular;
    end

    if (fwd_mag > thx) begin
      eval_o.cls = drs_pkg::ClsRunning;
    end else if (lat_mag > lat_th || hdg_mag > hdg_th) begin
      eval_o.cls = drs_pkg::ClsFailed;
    end else begin
      eval_o.cls = drs_pkg::ClsSuccess;
    end
  end

endmodule

[hdl/docking_retry_supervisor_top.sv]
// Top level of the docking retry supervisor: action state, retries and result register.
//
// The supervisor takes one request per cycle while the output side is ready and
// returns exactly one result per request, in order, from an output register.
// A request first lands in an input register; the clamps, the pose classifier and
// the action state update then work on it in one short combinational pass, and
// the result is written to an output register. The input register advances
// whenever the output register is empty or is being emptied in the same cycle,
// so a new request can be accepted in every cycle and a waiting result does not
// stop intake until both registers are full. The sustained rate is one request
// per clock while the output side is ready, set by the single pass from the input
// register to the output register. Configuration registers are written through a
// plain write port and are expected to change only while no request is in flight;
// writes to an index past the last register are ignored.
module docking_retry_supervisor_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  drs_pkg::req_t                      in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output drs_pkg::rsp_t                      out_rsp_o,
  input  logic                               cfg_we_i,
  input  logic [drs_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [drs_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  // Configuration registers.
  drs_pkg::cfg_t cfg_q;

  // Pipeline registers.
  drs_pkg::req_t s1_q;
  logic          s1_valid_q;
  drs_pkg::rsp_t out_q;
  logic          out_valid_q;

  // Action state.
  logic                                act_q, act_d;
  logic                                undock_q, undock_d;
  logic                                bo_q, bo_d;
  logic [drs_pkg::RetryWidth-1:0]      retries_q, retries_d;
  logic [drs_pkg::CountWidth-1:0]      fail_q, fail_d;
  logic [drs_pkg::CountWidth-1:0]      sens_q, sens_d;
  logic signed [drs_pkg::ValueWidth-1:0] held_lin_q, held_lin_d;
  logic signed [drs_pkg::ValueWidth-1:0] held_ang_q, held_ang_d;

  logic          s1_adv;
  logic          out_free;
  logic          done;
  drs_pkg::rsp_t res;
  drs_pkg::eval_t ev;
  logic [drs_pkg::CountWidth-1:0] lim_x;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign lim_x       = drs_pkg::CountWidth'(cfg_q.error_tick_limit);

  drs_eval u_eval (
    .req_i         (s1_q),
    .cfg_i         (cfg_q),
    .backing_out_i (bo_q),
    .eval_o        (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.error_tick_limit    <= 8'd50;
      cfg_q.retry_limit         <= 4'd3;
      cfg_q.forward_threshold   <= 13'd41;
      cfg_q.lateral_threshold   <= 15'd41;
      cfg_q.heading_threshold   <= 15'd41;
      cfg_q.linear_speed_limit  <= 15'd4096;
      cfg_q.angular_speed_limit <= 15'd4096;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        drs_pkg::CfgErrorTickLimit: begin
          cfg_q.error_tick_limit <= cfg_data_i[drs_pkg::LimitWidth-1:0];
        end
        drs_pkg::CfgRetryLimit: begin
          cfg_q.retry_limit <= cfg_data_i[drs_pkg::RetryWidth-1:0];
        end
        drs_pkg::CfgForwardTh: begin
          cfg_q.forward_threshold <= cfg_data_i[drs_pkg::FwdThWidth-1:0];
        end
        drs_pkg::CfgLateralTh: begin
          cfg_q.lateral_threshold <= cfg_data_i[drs_pkg::ThWidth-1:0];
        end
        drs_pkg::CfgHeadingTh: begin
          cfg_q.heading_threshold <= cfg_data_i[drs_pkg::ThWidth-1:0];
        end
        drs_pkg::CfgLinearLimit: begin
          cfg_q.linear_speed_limit <= cfg_data_i[drs_pkg::ThWidth-1:0];
        end
        drs_pkg::CfgAngularLimit: begin
          cfg_q.angular_speed_limit <= cfg_data_i[drs_pkg::ThWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Next action state and result for the request held in the input register.
  always_comb begin
    act_d      = act_q;
    undock_d   = undock_q;
    bo_d       = bo_q;
    retries_d  = retries_q;
    fail_d     = fail_q;
    sens_d     = sens_q;
    held_lin_d = held_lin_q;
    held_ang_d = held_ang_q;
    done       = 1'b0;
    res        = '{status: drs_pkg::StIdle, linear_command: '0,
                   angular_command: '0, retry_target: 1'b0};

    if (s1_q.opcode == drs_pkg::OpStartDock || s1_q.opcode == drs_pkg::OpStartUndock) begin
      // A start drops any running action and opens a fresh one.
      act_d      = 1'b1;
      undock_d   = (s1_q.opcode == drs_pkg::OpStartUndock);
      bo_d       = (s1_q.opcode == drs_pkg::OpStartUndock);
      retries_d  = cfg_q.retry_limit;
      fail_d     = '0;
      sens_d     = '0;
      held_lin_d = '0;
      held_ang_d = '0;
      res.status       = drs_pkg::StStarted;
      res.retry_target = bo_d;
    end else if (!act_q) begin
      res.status = drs_pkg::StIdle;
    end else if (s1_q.preempt_request) begin
      done       = 1'b1;
      res.status = drs_pkg::StPreempted;
    end else if (!s1_q.sensor_valid) begin
      if (sens_q != '1) begin
        sens_d = sens_q + 1'b1;
      end
      if (sens_q > lim_x) begin
        done       = 1'b1;
        res.status = drs_pkg::StSensorAbort;
      end else begin
        // Keep driving the last command while the sensor is out.
        res.status          = drs_pkg::StRunning;
        res.linear_command  = held_lin_q;
        res.angular_command = held_ang_q;
        res.retry_target    = bo_q;
      end
    end else begin
      if (undock_q) begin
        if (ev.cls == drs_pkg::ClsSuccess) begin
          done       = 1'b1;
          res.status = drs_pkg::StSucceeded;
        end else if (ev.cls == drs_pkg::ClsFailed) begin
          done       = 1'b1;
          res.status = drs_pkg::StUndockFailed;
        end
      end else begin
        if (ev.cls == drs_pkg::ClsSuccess && !bo_q) begin
          done       = 1'b1;
          res.status = drs_pkg::StSucceeded;
        end else if (ev.cls == drs_pkg::ClsFailed) begin
          if (fail_q != '1) begin
            fail_d = fail_q + 1'b1;
          end
          if (fail_q > lim_x) begin
            if (retries_q == '0) begin
              done       = 1'b1;
              res.status = drs_pkg::StRetriesOut;
            end else begin
              // Returning from the back-out offset spends one retry.
              if (bo_q) begin
                retries_d = retries_q - 1'b1;
              end
              bo_d   = !bo_q;
              fail_d = '0;
            end
          end
        end
      end
      if (!done) begin
        held_lin_d          = ev.lin;
        held_ang_d          = ev.ang;
        res.status          = drs_pkg::StRunning;
        res.linear_command  = ev.lin;
        res.angular_command = ev.ang;
        res.retry_target    = bo_d;
      end
    end

    if (done) begin
      // Every ending result carries zero commands and no retry target.
      act_d               = 1'b0;
      bo_d                = 1'b0;
      res.linear_command  = '0;
      res.angular_command = '0;
      res.retry_target    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      act_q       <= 1'b0;
      undock_q    <= 1'b0;
      bo_q        <= 1'b0;
      retries_q   <= '0;
      fail_q      <= '0;
      sens_q      <= '0;
      held_lin_q  <= '0;
      held_ang_q  <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        act_q      <= act_d;
        undock_q   <= undock_d;
        bo_q       <= bo_d;
        retries_q  <= retries_d;
        fail_q     <= fail_d;
        sens_q     <= sens_d;
        held_lin_q <= held_lin_d;
        held_ang_q <= held_ang_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_req_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  // An empty result register always lets the input side move.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled while the result register is empty");

  // A finishing request leaves the action closed and the target cleared.
  a_finish_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && done |=> !act_q && !bo_q)
    else $error("action still open after an ending result");

  // Ending results drive zero commands and no retry target.
  a_finish_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == drs_pkg::StSucceeded ||
                    out_q.status == drs_pkg::StPreempted ||
                    out_q.status == drs_pkg::StRetriesOut ||
                    out_q.status == drs_pkg::StSensorAbort ||
                    out_q.status == drs_pkg::StUndockFailed)
    |-> out_q.linear_command == '0 && out_q.angular_command == '0 && !out_q.retry_target)
    else $error("ending result carries a nonzero command");
`endif

endmodule
